// File: hw/rtl/khm_pkg.sv
// ----------------------------------------------------------------------------
// khm_pkg: shared definitions for the k-th largest tracker
// Widths, default sizes, the sift engine state type and the engine status.
// ----------------------------------------------------------------------------
package khm_pkg;

	localparam int VAL_W     = 32;
	localparam int KCFG_W    = 7;
	localparam int K_MAX_DEF = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DONE
	} khm_state_t;

	// Status that the sift engine reports to the stream side.
	typedef struct packed {
		logic                    idle;
		logic                    done;
		logic                    full;
		logic signed [VAL_W-1:0] root;
	} khm_stat_t;

endpackage

// File: hw/rtl/khm_ram.sv
// ----------------------------------------------------------------------------
// khm_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module khm_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                         wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_a,
	output logic [W-1:0]                         rdata_a,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_b,
	output logic [W-1:0]                         rdata_b
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hw/rtl/khm_sift.sv
// ----------------------------------------------------------------------------
// khm_sift: heap update engine
// Holds the moving value in a register and walks the heap in the RAM,
// one level per read and compare-write pair, for sift-up and sift-down.
// ----------------------------------------------------------------------------
module khm_sift #(
	parameter int K_MAX = khm_pkg::K_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [khm_pkg::VAL_W-1:0]    value,
	input  logic [$clog2(K_MAX+1)-1:0]          keff,
	input  logic                                ack,
	output khm_pkg::khm_stat_t                  stat
);
	import khm_pkg::*;

	localparam int CW = $clog2(K_MAX + 1);
	localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
	localparam int IW = AW + 2;

	khm_state_t state_q, state_d;
	logic [AW-1:0]           pos_q, pos_d;
	logic [CW-1:0]           cnt_q, cnt_d;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] root_q;

	logic             we;
	logic [AW-1:0]    waddr, raddr_a, raddr_b;
	logic [VAL_W-1:0] wdata, rdata_a, rdata_b;

	logic [AW-1:0]           parent;
	logic [IW-1:0]           left_w, right_w, cnt_w;
	logic                    take_l, take_r;
	logic signed [VAL_W-1:0] min_lv;

	khm_ram #(.W(VAL_W), .D(K_MAX)) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	assign parent  = (pos_q - AW'(1)) >> 1;
	assign left_w  = IW'({pos_q, 1'b1});
	assign right_w = left_w + IW'(1);
	assign cnt_w   = IW'(cnt_q);

	// Sift-down choice: left wins ties, right only when strictly smaller.
	assign take_l = $signed(rdata_a) < val_q;
	assign min_lv = take_l ? $signed(rdata_a) : val_q;
	assign take_r = (right_w < cnt_w) && ($signed(rdata_b) < min_lv);

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		cnt_d   = cnt_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = val_q;
		raddr_a = parent;
		raddr_b = right_w[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cnt_q < keff) begin
						pos_d   = cnt_q[AW-1:0];
						cnt_d   = cnt_q + CW'(1);
						state_d = ST_UP_RD;
					end else if (value > root_q) begin
						pos_d   = '0;
						state_d = ST_DN_RD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_UP_RD: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				we = 1'b1;
				if (val_q < $signed(rdata_a)) begin
					wdata   = rdata_a;
					pos_d   = parent;
					state_d = ST_UP_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DN_RD: begin
				raddr_a = left_w[AW-1:0];
				if (left_w >= cnt_w) begin
					we      = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				we = 1'b1;
				if (take_r) begin
					wdata   = rdata_b;
					pos_d   = right_w[AW-1:0];
					state_d = ST_DN_RD;
				end else if (take_l) begin
					wdata   = rdata_a;
					pos_d   = left_w[AW-1:0];
					state_d = ST_DN_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (ack) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
		end
	end

	// The root is mirrored in a register so the drop test needs no read.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			val_q <= value;
		end
		if (we && waddr == '0) begin
			root_q <= $signed(wdata);
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign stat.full = (cnt_q >= keff);
	assign stat.root = root_q;

endmodule

// File: hw/rtl/kth_largest_min_heap_tracker.sv
// A value no larger than the root of a full heap is dropped without touching the heap;
// otherwise it is sifted up (heap not full) or down (full) before its result is given.
// One request at a time: the sift loop over the heap RAM (one read and one
// compare-write per level) must finish before the next request is taken.
// Reset (arst_n low, asynchronous): heap empty, k_target = 1, no result pending.
// The heap RAM is not cleared; only entries already written are ever read.
// ----------------------------------------------------------------------------
// kth_largest_min_heap_tracker: running k-th largest value of a stream
// Keeps the k largest signed values seen so far in a RAM-based min-heap and
// returns the root and a full flag for every request.
// ----------------------------------------------------------------------------
module kth_largest_min_heap_tracker #(
	parameter int K_MAX = khm_pkg::K_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream. s_tdata: value[31:0].
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic signed [khm_pkg::VAL_W-1:0]  s_tdata,
	// Result stream. m_tdata: kth_value[31:0]. m_tuser: heap_full[0].
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic signed [khm_pkg::VAL_W-1:0]  m_tdata,
	output logic                              m_tuser,
	// Configuration: k_target, written whenever cfg_we is high.
	input  logic                              cfg_we,
	input  logic [khm_pkg::KCFG_W-1:0]        cfg_wdata
);
	import khm_pkg::*;

	localparam int CW = $clog2(K_MAX + 1);

	logic [KCFG_W-1:0] k_q;
	logic [CW-1:0]     keff;
	khm_stat_t         stat;
	logic              start;
	logic              ack;

	// The rank register. Out-of-range settings are clamped into 1..K_MAX
	// below, so a zero acts as one and oversize values act as K_MAX.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KCFG_W'(1);
		end else if (cfg_we) begin
			k_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (k_q == '0) begin
			keff = CW'(1);
		end else if (int'(k_q) > K_MAX) begin
			keff = CW'(K_MAX);
		end else begin
			keff = CW'(k_q);
		end
	end

	// A new request is taken whenever the engine is idle, even while the
	// previous result still sits in the output register.
	assign s_tready = stat.idle;
	assign start    = s_tvalid && s_tready;

	khm_sift #(.K_MAX(K_MAX)) u_sift (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.value (s_tdata),
		.keff  (keff),
		.ack   (ack),
		.stat  (stat)
	);

	// The engine holds its finished result until the output register is free.
	assign ack = stat.done && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ack) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Result payload; the full flag compares the held count with the clamped k.
	always_ff @(posedge clk) begin
		if (ack) begin
			m_tdata <= stat.root;
			m_tuser <= stat.full;
		end
	end

endmodule

// File: hw/rtl/khm_checker.sv
// ----------------------------------------------------------------------------
// khm_checker: port-level checks for the k-th largest tracker
// Watches requests and results and checks ordering and heap monotonicity.
// ----------------------------------------------------------------------------
module khm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic signed [khm_pkg::VAL_W-1:0]  s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic signed [khm_pkg::VAL_W-1:0]  m_tdata,
	input logic                              m_tuser,
	input logic                              cfg_we,
	input logic [khm_pkg::KCFG_W-1:0]        cfg_wdata
);
	import khm_pkg::*;

	logic                    in_acc, out_acc;
	logic [1:0]              pend_q;
	logic                    full_seen_q;
	logic signed [VAL_W-1:0] last_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Requests taken but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// Once a full result is seen, the heap stays full and the root never
	// falls, until the rank is rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_seen_q <= 1'b0;
		end else if (cfg_we) begin
			full_seen_q <= 1'b0;
		end else if (out_acc && m_tuser) begin
			full_seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			last_q <= m_tdata;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 2'd0)
		else $error("result without a pending request");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests in flight");

	a_stays_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && full_seen_q && !cfg_we |-> m_tuser)
		else $error("heap lost its full state without a rank change");

	a_root_rises: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && full_seen_q && !cfg_we |-> m_tdata >= last_q)
		else $error("k-th largest value decreased");

	logic unused_ok;
	assign unused_ok = ^{s_tdata, cfg_wdata};

endmodule

bind kth_largest_min_heap_tracker khm_checker u_khm_checker (.*);
